@@ rtl/ivr_pkg.sv @@
// ----------------------------------------------------------------------------
// ivr_pkg
// Shared types and constants for the interval-to-RMS/average velocity block:
// default widths, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package ivr_pkg;

    // Default field widths
    localparam int VELOCITY_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF    = 16;

    // Output mode register codes
    localparam logic MODE_RMS = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_AB,
        S_MUL_BB,
        S_ACC_BB,
        S_DIV_INIT,
        S_DIV,
        S_SQ_INIT,
        S_SQRT,
        S_OUT
    } ivr_state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MUL_AA,
        MUL_AB,
        MUL_BB
    } ivr_mul_sel_t;

    // Source of the reported velocity
    typedef enum logic [1:0] {
        RES_PASS,
        RES_QUO,
        RES_ROOT
    } ivr_res_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         load;
        logic         first;
        logic         mul_en;
        ivr_mul_sel_t mul_sel;
        logic         add_prod;
        logic         add_avg;
        logic         div_init;
        logic         div_step;
        logic         sq_init;
        logic         sq_step;
        logic         out_load;
        ivr_res_sel_t res_sel;
    } ivr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_max;
        logic avg_mode;
        logic div_last;
        logic sq_last;
    } ivr_status_t;

endpackage

@@ rtl/ivr_sample_if.sv @@
// ----------------------------------------------------------------------------
// ivr_sample_if / ivr_result_if
// Valid/ready channels carrying input samples and result items.
// ----------------------------------------------------------------------------
interface ivr_sample_if #(
    parameter int VELOCITY_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [VELOCITY_BITS-1:0] velocity_in;
    logic                     end_of_trace;

    modport source (output valid, output velocity_in, output end_of_trace, input ready);
    modport sink   (input valid, input velocity_in, input end_of_trace, output ready);
endinterface

interface ivr_result_if #(
    parameter int VELOCITY_BITS = 16,
    parameter int INDEX_BITS    = 16
);
    logic                     valid;
    logic                     ready;
    logic [VELOCITY_BITS-1:0] velocity_out;
    logic [INDEX_BITS-1:0]    sample_index;
    logic                     last_of_trace;

    modport source (output valid, output velocity_out, output sample_index,
                    output last_of_trace, input ready);
    modport sink   (input valid, input velocity_out, input sample_index,
                    input last_of_trace, output ready);
endinterface

@@ rtl/interval_velocity_to_rms_or_average.sv @@
// ----------------------------------------------------------------------------
// interval_velocity_to_rms_or_average
// Running RMS or time-average velocity of an interval-velocity trace.
// ----------------------------------------------------------------------------
// The first sample of a trace passes straight through; later samples go
// through the bit-serial divider in average mode, and through the divider
// and then the bit-serial square root in RMS mode. One item at a time: the
// next sample is taken the cycle after the result is loaded into the output
// register. Reset (rst_n low, asynchronous) clears the trace state, the mode
// register (RMS) and the output valid flag.
module interval_velocity_to_rms_or_average
    import ivr_pkg::*;
#(
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ivr_sample_if.sink   samples,
    ivr_result_if.source results,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);

    ivr_cmd_t    cmd;
    ivr_status_t status;

    // Sequence the per-sample work
    ivr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and trace state
    ivr_datapath #(
        .VELOCITY_BITS (VELOCITY_BITS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .velocity_in   (samples.velocity_in),
        .end_of_trace  (samples.end_of_trace),
        .velocity_out  (results.velocity_out),
        .sample_index  (results.sample_index),
        .last_of_trace (results.last_of_trace)
    );

endmodule

@@ rtl/ivr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ivr_ctrl
// Controller: sequences term accumulation, the divider and the square root,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module ivr_ctrl
    import ivr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ivr_status_t status,
    output ivr_cmd_t    cmd
);

    ivr_state_t   state_reg, state_next;
    ivr_res_sel_t res_sel_reg, res_sel_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // State and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_sel_reg   <= RES_PASS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.first      = 1'b0;
        cmd.mul_en     = 1'b0;
        cmd.mul_sel    = MUL_AA;
        cmd.add_prod   = 1'b0;
        cmd.add_avg    = 1'b0;
        cmd.div_init   = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.sq_init    = 1'b0;
        cmd.sq_step    = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.res_sel    = res_sel_reg;

        // drop valid once the result transaction completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.cnt_zero)
                begin
                    cmd.first    = 1'b1;
                    res_sel_next = RES_PASS;
                    state_next   = S_OUT;
                end
                else if (status.cnt_max)
                begin
                    state_next = S_DIV_INIT;
                end
                else if (status.avg_mode)
                begin
                    cmd.add_avg = 1'b1;
                    state_next  = S_DIV_INIT;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_AA;
                    state_next  = S_MUL_AB;
                end
            end
            S_MUL_AB:
            begin
                cmd.add_prod = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_AB;
                state_next   = S_MUL_BB;
            end
            S_MUL_BB:
            begin
                cmd.add_prod = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_BB;
                state_next   = S_ACC_BB;
            end
            S_ACC_BB:
            begin
                cmd.add_prod = 1'b1;
                state_next   = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    if (status.avg_mode)
                    begin
                        res_sel_next = RES_QUO;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SQ_INIT;
                    end
                end
            end
            S_SQ_INIT:
            begin
                cmd.sq_init = 1'b1;
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (status.sq_last)
                begin
                    res_sel_next = RES_ROOT;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ivr_datapath.sv @@
// ----------------------------------------------------------------------------
// ivr_datapath
// Trace state, shared multiplier, restoring divider, digit-by-digit square
// root and the output register.
// ----------------------------------------------------------------------------
module ivr_datapath
    import ivr_pkg::*;
#(
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ivr_cmd_t                 cmd,
    output ivr_status_t              status,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic [VELOCITY_BITS-1:0] velocity_in,
    input  logic                     end_of_trace,
    output logic [VELOCITY_BITS-1:0] velocity_out,
    output logic [INDEX_BITS-1:0]    sample_index,
    output logic                     last_of_trace
);

    localparam int VB  = VELOCITY_BITS;
    localparam int IB  = INDEX_BITS;
    localparam int SW  = 2 * VB + 2 + IB;
    localparam int DW  = IB + 2;
    localparam int ITW = $clog2(SW);

    // Trace state (reset) and working registers (no reset)
    logic              mode_reg;
    logic [IB-1:0]     cnt_reg;
    logic [VB-1:0]     prev_reg;
    logic [SW-1:0]     sum_reg;
    logic [VB-1:0]     v_reg;
    logic              eot_reg;
    logic [2*VB-1:0]   prod_reg;
    logic [DW-1:0]     dvs_reg;
    logic [DW-1:0]     rem_reg;
    logic [SW-1:0]     quo_reg;
    logic [2*VB-1:0]   rad_reg;
    logic [VB+1:0]     srem_reg;
    logic [VB-1:0]     root_reg;
    logic [ITW-1:0]    iter_reg;
    logic [IB-1:0]     idx_reg;
    logic [VB-1:0]     vel_out_reg;
    logic [IB-1:0]     idx_out_reg;
    logic              last_out_reg;

    logic              cnt_max;
    logic [IB-1:0]     div_n;
    logic [DW-1:0]     n_ext;
    logic [DW-1:0]     two_n;
    logic [DW-1:0]     dvs_next;
    logic [VB-1:0]     mul_a;
    logic [VB-1:0]     mul_b;
    logic [VB:0]       avg_term;
    logic [DW:0]       div_shift;
    logic [DW:0]       div_diff;
    logic              div_ge;
    logic [VB+3:0]     sq_r4;
    logic [VB+3:0]     sq_trial;
    logic [VB+3:0]     sq_diff;
    logic              sq_ge;

    assign cnt_max         = &cnt_reg;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.cnt_max  = cnt_max;
    assign status.avg_mode = (mode_reg == MODE_AVG);
    assign status.div_last = (iter_reg == '0);
    assign status.sq_last  = (iter_reg == '0);

    // Divisor: 2n for average, 3n for RMS; an overlong trace holds n at all ones minus one
    assign div_n    = cnt_max ? (cnt_reg - IB'(1)) : cnt_reg;
    assign n_ext    = {2'b00, div_n};
    assign two_n    = {1'b0, div_n, 1'b0};
    assign dvs_next = (mode_reg == MODE_AVG) ? two_n : (two_n + n_ext);

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AA:
            begin
                mul_a = prev_reg;
                mul_b = prev_reg;
            end
            MUL_AB:
            begin
                mul_a = prev_reg;
                mul_b = v_reg;
            end
            MUL_BB:
            begin
                mul_a = v_reg;
                mul_b = v_reg;
            end
            default:
            begin
                mul_a = prev_reg;
                mul_b = v_reg;
            end
        endcase
    end

    assign avg_term = {1'b0, prev_reg} + {1'b0, v_reg};

    // One restoring division step
    assign div_shift = {rem_reg, quo_reg[SW-1]};
    assign div_diff  = div_shift - {1'b0, dvs_reg};
    assign div_ge    = (div_shift >= {1'b0, dvs_reg});

    // One square root digit
    assign sq_r4    = {srem_reg, rad_reg[2*VB-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_diff  = sq_r4 - sq_trial;
    assign sq_ge    = (sq_r4 >= sq_trial);

    // Mode register and trace state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RMS;
            cnt_reg  <= '0;
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.first)
            begin
                prev_reg <= v_reg;
                cnt_reg  <= IB'(1);
            end
            if (cmd.add_prod)
            begin
                sum_reg <= sum_reg + SW'(prod_reg);
            end
            if (cmd.add_avg)
            begin
                sum_reg <= sum_reg + SW'(avg_term);
            end
            if (cmd.div_init && !cnt_max)
            begin
                prev_reg <= v_reg;
                cnt_reg  <= cnt_reg + IB'(1);
            end
            // clear the trace after its last sample goes out
            if (cmd.out_load && eot_reg)
            begin
                cnt_reg  <= '0;
                prev_reg <= '0;
                sum_reg  <= '0;
            end
        end
    end

    // Working registers: capture, multiply, divide, root and output
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg   <= velocity_in;
            eot_reg <= end_of_trace;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= {{VB{1'b0}}, mul_a} * {{VB{1'b0}}, mul_b};
        end
        if (cmd.first)
        begin
            idx_reg <= '0;
        end
        if (cmd.div_init)
        begin
            idx_reg  <= cnt_reg;
            dvs_reg  <= dvs_next;
            rem_reg  <= '0;
            quo_reg  <= sum_reg;
            iter_reg <= ITW'(SW - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
            quo_reg  <= {quo_reg[SW-2:0], div_ge};
            iter_reg <= iter_reg - ITW'(1);
        end
        if (cmd.sq_init)
        begin
            rad_reg  <= quo_reg[2*VB-1:0];
            srem_reg <= '0;
            root_reg <= '0;
            iter_reg <= ITW'(VB - 1);
        end
        if (cmd.sq_step)
        begin
            srem_reg <= sq_ge ? sq_diff[VB+1:0] : sq_r4[VB+1:0];
            root_reg <= {root_reg[VB-2:0], sq_ge};
            rad_reg  <= {rad_reg[2*VB-3:0], 2'b00};
            iter_reg <= iter_reg - ITW'(1);
        end
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                RES_PASS: vel_out_reg <= v_reg;
                RES_QUO:  vel_out_reg <= quo_reg[VB-1:0];
                RES_ROOT: vel_out_reg <= root_reg;
                default:  vel_out_reg <= v_reg;
            endcase
            idx_out_reg  <= idx_reg;
            last_out_reg <= eot_reg;
        end
    end

    assign velocity_out  = vel_out_reg;
    assign sample_index  = idx_out_reg;
    assign last_of_trace = last_out_reg;

endmodule

@@ rtl/ivr_checker.sv @@
// ----------------------------------------------------------------------------
// ivr_checker
// Port-level checks on the velocity block, bound to the top level.
// ----------------------------------------------------------------------------
module ivr_checker
    import ivr_pkg::*;
#(
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [VELOCITY_BITS-1:0] velocity_out,
    input logic [INDEX_BITS-1:0]    sample_index,
    input logic                     last_of_trace
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(velocity_out)
            && $stable(sample_index) && $stable(last_of_trace))
        else $error("stalled result changed");

    // Block stays busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready high the cycle after a sample transaction");

    // A new result appears only after a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a busy cycle");

    // No result during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind interval_velocity_to_rms_or_average ivr_checker #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .INDEX_BITS    (INDEX_BITS)
) u_ivr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .velocity_out  (results.velocity_out),
    .sample_index  (results.sample_index),
    .last_of_trace (results.last_of_trace)
);

@@ tb/tb_interval_velocity_to_rms_or_average.sv @@
// ----------------------------------------------------------------------------
// tb_interval_velocity_to_rms_or_average
// Self-checking bench for the running RMS / time-average velocity block.
// A directed table covers both modes, full-scale and zero samples,
// single-sample traces and mode flips inside a trace; one trace is then
// sent back to back. Random traces follow. The sender and the
// receiver idle and stall at random. Every result is compared field by
// field with a local prediction of the velocity arithmetic, or with the table's typed values.
// ----------------------------------------------------------------------------
module tb_interval_velocity_to_rms_or_average;
    import ivr_pkg::*;

    localparam int VW = VELOCITY_BITS_DEF;
    localparam int IW = INDEX_BITS_DEF;
    localparam logic [IW-1:0] INDEX_FULL = {IW{1'b1}};
    localparam int RANDOM_ITEMS  = 700;
    localparam int BURST_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 2_000_000;

    // One result transaction as the block should report it
    typedef struct packed {
        logic [VW-1:0] vel;
        logic [IW-1:0] idx;
        logic          last;
    } vel_result_t;

    // One row of the directed table
    typedef struct packed {
        logic          mode;
        logic [VW-1:0] vel;
        logic          eot;
        logic          typed;
        logic [VW-1:0] exp_vel;
        logic [IW-1:0] exp_idx;
    } trace_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ivr_sample_if #(.VELOCITY_BITS(VW)) samples_if ();
    ivr_result_if #(.VELOCITY_BITS(VW), .INDEX_BITS(IW)) results_if ();

    interval_velocity_to_rms_or_average u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predicted trace state and mode register
    logic          active_mode;
    logic [IW-1:0] trc_count;
    logic [VW-1:0] trc_prev;
    logic [63:0]   trc_sum;

    vel_result_t expected_results[$];
    trace_row_t  trace_table[$];

    longint cycle_count;
    int     mismatch_count;
    int     items_sent;
    int     burst_left;
    bit     no_idle;
    int     rx_left;
    int     rx_kind;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Floor of the square root of a 64-bit value, one root bit at a time
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Velocity from the running sum over n intervals, per the current mode
    function automatic logic [VW-1:0] mean_velocity(input logic [IW-1:0] n);
        logic [63:0] q;
        if (active_mode == MODE_AVG)
            q = trc_sum / (64'(n) * 64'd2);
        else
            q = floor_sqrt(trc_sum / (64'(n) * 64'd3));
        return q[VW-1:0];
    endfunction

    // Advance the trace state by one sample and return the velocity it reports
    function automatic vel_result_t predict_velocity(input logic [VW-1:0] v,
                                                     input logic eot);
        vel_result_t r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] term;
        a = 64'(trc_prev);
        b = 64'(v);
        if (trc_count == '0)
        begin
            // First sample passes through
            r.vel     = v;
            r.idx     = '0;
            trc_prev  = v;
            trc_count = IW'(1);
        end
        else if (trc_count != INDEX_FULL)
        begin
            term      = (active_mode == MODE_AVG) ? (a + b) : (a * a + a * b + b * b);
            trc_sum   = trc_sum + term;
            trc_prev  = v;
            r.idx     = trc_count;
            r.vel     = mean_velocity(trc_count);
            trc_count = trc_count + 1'b1;
        end
        else
        begin
            // Counter saturated: repeat the last accumulated value
            r.idx = INDEX_FULL;
            r.vel = mean_velocity(INDEX_FULL - 1'b1);
        end
        r.last = eot;
        if (eot)
        begin
            trc_count = '0;
            trc_prev  = '0;
            trc_sum   = '0;
        end
        return r;
    endfunction

    function automatic trace_row_t mk_row(input logic mode, input logic [VW-1:0] vel,
                                          input logic eot, input logic typed,
                                          input logic [VW-1:0] exp_vel,
                                          input logic [IW-1:0] exp_idx);
        trace_row_t row;
        row.mode    = mode;
        row.vel     = vel;
        row.eot     = eot;
        row.typed   = typed;
        row.exp_vel = exp_vel;
        row.exp_idx = exp_idx;
        return row;
    endfunction

    function automatic logic [VW-1:0] rand_velocity();
        logic [VW-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = {VW{1'b1}};
            2: v = VW'($urandom_range(0, 255));
            3: v = {VW{1'b1}} - VW'($urandom_range(0, 255));
            default: v = VW'($urandom);
        endcase
        return v;
    endfunction

    // Send one sample transaction; call and return at a falling edge
    task automatic send_sample(input logic [VW-1:0] v, input logic eot, input logic typed,
                               input logic [VW-1:0] t_vel, input logic [IW-1:0] t_idx);
        int          gap;
        vel_result_t pred;
        if (!no_idle && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
                                                     : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        samples_if.velocity_in  <= v;
        samples_if.end_of_trace <= eot;
        samples_if.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!samples_if.ready);
        pred = predict_velocity(v, eot);
        if (typed)
        begin
            pred.vel = t_vel;
            pred.idx = t_idx;
        end
        expected_results.push_back(pred);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic hold_until_drained();
        samples_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic set_mode(input logic m);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        active_mode = m;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        vel_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result vel %0d idx %0d",
                                          results_if.velocity_out, results_if.sample_index));
            end
            else
            begin
                want = expected_results.pop_front();
                if (results_if.velocity_out !== want.vel)
                    report_mismatch($sformatf("velocity_out %0d, expected %0d (idx %0d)",
                                              results_if.velocity_out, want.vel, want.idx));
                if (results_if.sample_index !== want.idx)
                    report_mismatch($sformatf("sample_index %0d, expected %0d",
                                              results_if.sample_index, want.idx));
                if (results_if.last_of_trace !== want.last)
                    report_mismatch($sformatf("last_of_trace %0b, expected %0b (idx %0d)",
                                              results_if.last_of_trace, want.last, want.idx));
            end
        end
    end

    // Receiver: steady runs, stalls and coin-flip stretches
    initial
    begin
        results_if.ready = 1'b0;
        rx_left = 0;
        rx_kind = 0;
        forever
        begin
            @(negedge clk);
            if (no_idle)
            begin
                results_if.ready <= 1'b1;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_kind = $urandom_range(0, 2);
                    rx_left = (rx_kind == 1) ? $urandom_range(1, 40) : $urandom_range(4, 80);
                end
                rx_left--;
                case (rx_kind)
                    0: results_if.ready <= 1'b1;
                    1: results_if.ready <= 1'b0;
                    default: results_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Main sequence
    initial
    begin
        int trace_len;
        trace_row_t row;

        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = 1'b0;
        samples_if.valid        = 1'b0;
        samples_if.velocity_in  = '0;
        samples_if.end_of_trace = 1'b0;
        active_mode             = MODE_RMS;
        trc_count               = '0;
        trc_prev                = '0;
        trc_sum                 = '0;
        cycle_count             = 0;
        mismatch_count          = 0;
        items_sent              = 0;
        burst_left              = 0;
        no_idle                 = 1'b0;

        // Directed table: mode, velocity, end of trace, typed, velocity, index
        trace_table.push_back(mk_row(MODE_RMS, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'd0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'd1));
        trace_table.push_back(mk_row(MODE_RMS, 16'h0000, 1'b1, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'd0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'd0));
        trace_table.push_back(mk_row(MODE_AVG, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'd0));
        trace_table.push_back(mk_row(MODE_AVG, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'd1));
        trace_table.push_back(mk_row(MODE_AVG, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'd0));
        trace_table.push_back(mk_row(MODE_AVG, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'd1));
        trace_table.push_back(mk_row(MODE_AVG, 16'h0001, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_AVG, 16'hFFFF, 1'b0, 1'b0, '0, '0));
        // Flip the mode inside the open trace
        trace_table.push_back(mk_row(MODE_RMS, 16'h5555, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hAAAA, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_AVG, 16'h8000, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_AVG, 16'h7FFF, 1'b1, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'd0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hFFFF, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'h0000, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hFFFF, 1'b1, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_AVG, 16'h1234, 1'b0, 1'b1, 16'h1234, 16'd0));
        trace_table.push_back(mk_row(MODE_AVG, 16'h1234, 1'b1, 1'b1, 16'h1234, 16'd1));
        trace_table.push_back(mk_row(MODE_RMS, 16'h00FF, 1'b0, 1'b1, 16'h00FF, 16'd0));
        trace_table.push_back(mk_row(MODE_RMS, 16'hFF00, 1'b0, 1'b0, '0, '0));
        trace_table.push_back(mk_row(MODE_RMS, 16'h0F0F, 1'b1, 1'b0, '0, '0));

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        set_mode(MODE_RMS);
        foreach (trace_table[i])
        begin
            row = trace_table[i];
            if (row.mode != active_mode)
                set_mode(row.mode);
            send_sample(row.vel, row.eot, row.typed, row.exp_vel, row.exp_idx);
        end

        // Run one trace back to back with the receiver always ready
        set_mode(MODE_AVG);
        no_idle = 1'b1;
        for (int n = 0; n < BURST_ITEMS; n++)
            send_sample(VW'($urandom), 1'b0, 1'b0, '0, '0);
        send_sample(VW'($urandom), 1'b1, 1'b0, '0, '0);
        hold_until_drained();
        no_idle = 1'b0;

        // Random traces
        set_mode(MODE_RMS);
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                set_mode(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 11) == 0)
                hold_until_drained();
            trace_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
            for (int n = 0; n < trace_len; n++)
            begin
                if (n > 0 && $urandom_range(0, 29) == 0)
                    set_mode(~active_mode);
                send_sample(rand_velocity(), (n == trace_len - 1), 1'b0, '0, '0);
            end
        end

        // Drain and settle
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ivr_pkg.sv
rtl/ivr_sample_if.sv
rtl/ivr_ctrl.sv
rtl/ivr_datapath.sv
rtl/interval_velocity_to_rms_or_average.sv
rtl/ivr_checker.sv
tb/tb_interval_velocity_to_rms_or_average.sv
